>>> hw/rtl/pls_pkg.sv
// Shared types for the positional list store: operation and status codes,
// controller states and the packed input and result beats. No dependencies.
package pls_pkg;

  localparam int unsigned OpBits    = 3;
  localparam int unsigned PosBits   = 4;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned CountBits = 5;

  typedef enum logic [OpBits-1:0] {
    OP_ADD_FIRST  = 3'd0,
    OP_ADD_LAST   = 3'd1,
    OP_INSERT     = 3'd2,
    OP_TAKE_FIRST = 3'd3,
    OP_TAKE_LAST  = 3'd4,
    OP_ERASE      = 3'd5,
    OP_READ       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_EMPTY = 2'd2,
    STS_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_TAIL,
    S_PLACE,
    S_READ
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [PosBits-1:0]  position;
    logic [ByteBits-1:0] value;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic [ByteBits-1:0]  read_value;
    logic [CountBits-1:0] count;
  } out_t;

endpackage

>>> hw/rtl/pls_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
module pls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/positional_list_store.sv
// Positional list store: an ordered list of up to CAPACITY values kept in position order in
// one RAM, with push and pop at both ends, insert, erase and read at a position, and clear.
// Each input beat yields exactly one result beat carrying the status, the value read and the
// new count. Push back, pop back, clear and every rejected operation load their result in
// the accepting cycle, and so do push front into an empty list, pop front of a single entry
// and erase of the last entry; a read loads its result from S_READ, after the registered RAM
// read. Push front and insert move the entries at and after the target position up by one,
// one entry per cycle through the RAM's read and write ports, in S_SHIFT and S_TAIL, then
// write the new value in S_PLACE; pop front and erase move the following entries down
// through S_SHIFT and S_TAIL. One operation is in flight at a time; a new beat is taken
// only in idle while the result register is empty or being drained in that cycle.
// Depends on pls_pkg and pls_ram.
module positional_list_store #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pls_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pls_pkg::out_t out_data_o
);

  import pls_pkg::*;

  // Address, count and helper widths.
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned PCW  = (CW > PosBits) ? CW : PosBits;
  localparam int unsigned PAW  = (AW > PosBits) ? AW : PosBits;
  localparam int unsigned VEW  = (VALUE_BITS > ByteBits) ? VALUE_BITS : ByteBits;
  localparam int unsigned CNTW = (CW > CountBits) ? CW : CountBits;

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         src_q, src_d;
  logic [AW-1:0]         stop_q, stop_d;
  logic                  up_q, up_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  pend_q, pend_d;
  logic [AW-1:0]         pend_addr_q, pend_addr_d;
  logic                  out_valid_q;
  out_t                  out_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  logic                  full;
  logic                  empty;
  logic                  pos_ok;
  logic [AW-1:0]         pos_idx;
  logic [AW-1:0]         cnt_idx;
  logic [AW-1:0]         last_idx;
  logic [VALUE_BITS-1:0] val_in;
  logic [PAW-1:0]        pos_ext;
  logic [VEW-1:0]        val_ext;
  logic [VEW-1:0]        rd_ext;
  logic [CNTW-1:0]       cnt_ext;
  status_e               res_status;
  logic [ByteBits-1:0]   res_read;

  pls_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Handshake: work starts only from idle, and only when the result register will be free.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Occupancy and position checks against the current count.
  assign full    = (cnt_q == CW'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign pos_ok  = (PCW'(in_data_i.position) < PCW'(cnt_q));
  assign pos_ext = PAW'(in_data_i.position);
  assign pos_idx = pos_ext[AW-1:0];

  // The count below capacity always fits an address; at a power-of-two capacity the low bits wrap so that
  // the last index still comes out right.
  assign cnt_idx  = cnt_q[AW-1:0];
  assign last_idx = cnt_idx - AW'(1);

  // Input bytes are kept in the low VALUE_BITS bits.
  assign val_ext = VEW'(in_data_i.value);
  assign val_in  = val_ext[VALUE_BITS-1:0];
  assign rd_ext  = VEW'(ram_rdata);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    stop_d      = stop_q;
    up_d        = up_q;
    val_d       = val_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = src_q;
    out_load    = 1'b0;
    res_status  = STS_OK;
    res_read    = '0;

    // A moved entry lands in the cycle after its read, while the next read is issued.
    if (pend_q) begin
      ram_we = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.op)
            OP_ADD_FIRST: begin
              out_load = full || empty;
              if (full) begin
                res_status = STS_FULL;
              end else if (empty) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = val_in;
                cnt_d     = cnt_q + CW'(1);
              end else begin
                src_d   = last_idx;
                stop_d  = '0;
                up_d    = 1'b1;
                val_d   = val_in;
                state_d = S_SHIFT;
              end
            end
            OP_ADD_LAST: begin
              out_load = 1'b1;
              if (full) begin
                res_status = STS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_idx;
                ram_wdata = val_in;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            OP_INSERT: begin
              if (!pos_ok) begin
                out_load   = 1'b1;
                res_status = STS_RANGE;
              end else if (full) begin
                out_load   = 1'b1;
                res_status = STS_FULL;
              end else begin
                src_d   = last_idx;
                stop_d  = pos_idx;
                up_d    = 1'b1;
                val_d   = val_in;
                state_d = S_SHIFT;
              end
            end
            OP_TAKE_FIRST: begin
              if (empty) begin
                out_load   = 1'b1;
                res_status = STS_EMPTY;
              end else if (cnt_q == CW'(1)) begin
                out_load = 1'b1;
                cnt_d    = '0;
              end else begin
                src_d   = AW'(1);
                stop_d  = last_idx;
                up_d    = 1'b0;
                state_d = S_SHIFT;
              end
            end
            OP_TAKE_LAST: begin
              out_load = 1'b1;
              if (empty) begin
                res_status = STS_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            OP_ERASE: begin
              if (empty) begin
                out_load   = 1'b1;
                res_status = STS_EMPTY;
              end else if (!pos_ok) begin
                out_load   = 1'b1;
                res_status = STS_RANGE;
              end else if (pos_idx == last_idx) begin
                out_load = 1'b1;
                cnt_d    = cnt_q - CW'(1);
              end else begin
                src_d   = pos_idx + AW'(1);
                stop_d  = last_idx;
                up_d    = 1'b0;
                state_d = S_SHIFT;
              end
            end
            OP_READ: begin
              if (!pos_ok) begin
                out_load   = 1'b1;
                res_status = STS_RANGE;
              end else begin
                ram_raddr = pos_idx;
                state_d   = S_READ;
              end
            end
            OP_CLEAR: begin
              out_load = 1'b1;
              cnt_d    = '0;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // Read one source entry per cycle; it is written to its neighbor next cycle.
        ram_raddr   = src_q;
        pend_d      = 1'b1;
        pend_addr_d = up_q ? (src_q + AW'(1)) : (src_q - AW'(1));
        if (src_q == stop_q) begin
          state_d = S_TAIL;
        end else begin
          src_d = up_q ? (src_q - AW'(1)) : (src_q + AW'(1));
        end
      end
      S_TAIL: begin
        // The last moved entry is written here.
        if (up_q) begin
          state_d = S_PLACE;
        end else begin
          out_load = 1'b1;
          cnt_d    = cnt_q - CW'(1);
          state_d  = S_IDLE;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = stop_q;
        ram_wdata = val_q;
        out_load  = 1'b1;
        cnt_d     = cnt_q + CW'(1);
        state_d   = S_IDLE;
      end
      S_READ: begin
        out_load = 1'b1;
        res_read = rd_ext[ByteBits-1:0];
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The reported count is the count after the operation.
  assign cnt_ext = CNTW'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    stop_q      <= stop_d;
    up_q        <= up_d;
    val_q       <= val_d;
    pend_addr_q <= pend_addr_d;
    if (out_load) begin
      out_q.status     <= res_status;
      out_q.read_value <= res_read;
      out_q.count      <= cnt_ext[CountBits-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
